### design/cds_pkg.sv
// Shared constants, state codes and card decode for the card deck shuffler.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int SUIT_COUNT     = 4;
  localparam int RANKS_PER_SUIT = 13;
  localparam int LOWEST_RANK    = 2;
  localparam int DECK_CARDS     = SUIT_COUNT * RANKS_PER_SUIT;
  localparam int STORE_DEPTH    = 52;

  localparam int CODE_W = 6;
  localparam int SLOT_W = 6;
  localparam int WORD_W = 31;
  localparam int CNT_W  = $clog2(WORD_W);
  localparam int SUIT_W = 2;
  localparam int RANK_W = 4;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_RD_I  = 7'b0000100,
    ST_RD_J  = 7'b0001000,
    ST_CAP_J = 7'b0010000,
    ST_WR_I  = 7'b0100000,
    ST_WR_J  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [SUIT_W-1:0] suit;
    logic [RANK_W-1:0] rank;
  } card_t;

  // Split a card code into suit and rank by comparing against suit boundaries.
  function automatic card_t decode_card(code_t code);
    card_t                res;
    logic [SUIT_W-1:0]    suit;
    logic [CODE_W-1:0]    base;
    suit = '0;
    base = '0;
    for (int s = 1; s < SUIT_COUNT; s++) begin
      if (code >= CODE_W'(s * RANKS_PER_SUIT)) begin
        suit = SUIT_W'(s);
        base = CODE_W'(s * RANKS_PER_SUIT);
      end
    end
    res.suit = suit;
    res.rank = RANK_W'(code - base) + RANK_W'(LOWEST_RANK);
    return res;
  endfunction

endpackage

### design/cds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/card_deck_shuffler.sv
// Top level of the card deck shuffler: sequencer, serial remainder unit and deck store.
`timescale 1ns / 1ps

// One input transfer carries a 31-bit random word and yields one dealt card.
// At slot i the block forms j = i + word mod (cards - i), swaps slots i and j
// of the deck store and returns the suit and rank now fixed at slot i, with
// round_done set on the last slot; the slot counter then wraps and the next
// round reshuffles the order left behind. Each item passes through these steps
// before the next word can be accepted: the word is captured, then runs
// through the bit-serial restoring remainder unit (one word bit per cycle), both
// slots are read through the single read port of the deck RAM, and the swap is
// written back through its single write port. The input stalls from the accept
// until the card is presented. A finished card sits in an output register, so
// the next word is accepted while the previous card still waits. The deck comes
// out of reset in suit-major order (clubs to spades, two to ace) at once: a valid
// bit per slot makes an unwritten slot read as its own index, so no clearing pass.
module card_deck_shuffler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cds_pkg::WORD_W-1:0]  in_random_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cds_pkg::SUIT_W-1:0]  out_card_suit_o,
  output logic [cds_pkg::RANK_W-1:0]  out_card_rank_o,
  output logic                        out_round_done_o
);

  cds_pkg::state_e state_q, state_d;

  logic [cds_pkg::WORD_W-1:0] word_q, word_d;
  logic [cds_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [cds_pkg::SLOT_W-1:0] rem_q, rem_d;
  cds_pkg::slot_t             slot_q, slot_d;
  cds_pkg::slot_t             span_q, span_d;
  cds_pkg::slot_t             j_q, j_d;
  cds_pkg::code_t             di_q, di_d;
  cds_pkg::code_t             dj_q, dj_d;
  cds_pkg::slot_t             rd_addr_q;
  logic [cds_pkg::STORE_DEPTH-1:0] valid_q, valid_d;

  logic                       out_valid_q, out_valid_d;
  cds_pkg::card_t             out_card_q, out_card_d;
  logic                       out_last_q, out_last_d;

  logic                       in_xfer;
  logic                       out_free;
  logic                       last_slot;
  logic [cds_pkg::SLOT_W:0]   rem_shift;
  logic                       rem_ge;

  logic                       ram_we;
  cds_pkg::slot_t             ram_waddr;
  cds_pkg::code_t             ram_wdata;
  cds_pkg::slot_t             ram_raddr;
  cds_pkg::code_t             ram_rdata;
  cds_pkg::code_t             rd_code;

  assign in_stall_o = (state_q != cds_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_slot  = (slot_q == cds_pkg::SLOT_W'(cds_pkg::DECK_CARDS - 1));

  // Restoring remainder step: shift in the next word bit, subtract span if it fits.
  assign rem_shift = {rem_q, word_q[cds_pkg::WORD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, span_q});

  // An unwritten slot reads as its reset card, which is its own index.
  assign rd_code = valid_q[rd_addr_q] ? ram_rdata : rd_addr_q;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    slot_d      = slot_q;
    span_d      = span_q;
    j_d         = j_q;
    di_d        = di_q;
    dj_d        = dj_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_card_d  = out_card_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = dj_q;
    ram_raddr   = slot_q;

    // Drop the output once the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cds_pkg::ST_IDLE: begin
        if (in_xfer) begin
          word_d  = in_random_word_i;
          cnt_d   = cds_pkg::CNT_W'(cds_pkg::WORD_W - 1);
          rem_d   = '0;
          span_d  = cds_pkg::SLOT_W'(cds_pkg::DECK_CARDS) - slot_q;
          state_d = cds_pkg::ST_DIV;
        end
      end
      cds_pkg::ST_DIV: begin
        rem_d  = rem_ge ? cds_pkg::SLOT_W'(rem_shift - {1'b0, span_q})
                        : cds_pkg::SLOT_W'(rem_shift);
        word_d = {word_q[cds_pkg::WORD_W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = cds_pkg::ST_RD_I;
        end
      end
      cds_pkg::ST_RD_I: begin
        // Issue the read of slot i; j is final now.
        j_d       = slot_q + rem_q;
        ram_raddr = slot_q;
        state_d   = cds_pkg::ST_RD_J;
      end
      cds_pkg::ST_RD_J: begin
        di_d      = rd_code;
        ram_raddr = j_q;
        state_d   = cds_pkg::ST_CAP_J;
      end
      cds_pkg::ST_CAP_J: begin
        dj_d    = rd_code;
        state_d = cds_pkg::ST_WR_I;
      end
      cds_pkg::ST_WR_I: begin
        ram_we           = 1'b1;
        ram_waddr        = slot_q;
        ram_wdata        = dj_q;
        valid_d[slot_q]  = 1'b1;
        state_d          = cds_pkg::ST_WR_J;
      end
      cds_pkg::ST_WR_J: begin
        // Hold the second write until the output register can take the card.
        if (out_free) begin
          ram_we       = 1'b1;
          ram_waddr    = j_q;
          ram_wdata    = di_q;
          valid_d[j_q] = 1'b1;
          out_valid_d  = 1'b1;
          out_card_d   = cds_pkg::decode_card(dj_q);
          out_last_d   = last_slot;
          slot_d       = last_slot ? '0 : slot_q + 1'b1;
          state_d      = cds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cds_pkg::ST_IDLE;
      slot_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    span_q     <= span_d;
    j_q        <= j_d;
    di_q       <= di_d;
    dj_q       <= dj_d;
    rd_addr_q  <= ram_raddr;
    out_card_q <= out_card_d;
    out_last_q <= out_last_d;
  end

  cds_ram #(
    .WIDTH (cds_pkg::CODE_W),
    .DEPTH (cds_pkg::STORE_DEPTH),
    .AW    (cds_pkg::SLOT_W)
  ) u_deck_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_card_suit_o  = out_card_q.suit;
  assign out_card_rank_o  = out_card_q.rank;
  assign out_round_done_o = out_last_q;

  // Slot counter never leaves the deck.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < cds_pkg::SLOT_W'(cds_pkg::DECK_CARDS))
    else $error("slot counter outside deck");

  // Swap partner lies between the current slot and the deck end.
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::ST_WR_I) |->
      (j_q >= slot_q) && (j_q < cds_pkg::SLOT_W'(cds_pkg::DECK_CARDS)))
    else $error("swap slot out of range");

  // Remainder is below the span once the division ends.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::ST_RD_I) |-> (rem_q < span_q))
    else $error("remainder not below span");

  // A presented card carries a legal rank.
  a_rank_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_card_q.rank >= cds_pkg::RANK_W'(cds_pkg::LOWEST_RANK)) &&
      (out_card_q.rank < cds_pkg::RANK_W'(cds_pkg::LOWEST_RANK + cds_pkg::RANKS_PER_SUIT)))
    else $error("dealt rank out of range");

  // Slot counter wraps to zero after the last slot is dealt.
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::ST_WR_J && out_free && last_slot) |=> (slot_q == '0))
    else $error("slot counter did not wrap after last slot");

endmodule
